@@ rtl/rhtpb_pkg.sv @@
// Package for the refcounted hash table with page bump allocator.
// Holds status codes, register indexes, controller states and command/status structs.
`timescale 1ns / 1ps
package rhtpb_pkg;

	localparam int CFG_W = 21;

	typedef enum logic [1:0] {
		REG_TABLE_SLOTS = 2'd0,
		REG_PAGE_LOG2   = 2'd1,
		REG_FIRST_PAGE  = 2'd2,
		REG_TOTAL_PAGES = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOPAGES  = 3'd3,
		ST_DECR     = 3'd4,
		ST_FREED    = 3'd5,
		ST_NOTFOUND = 3'd6,
		ST_BADKEY   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_CHECK,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;   // write zero at clear pointer, advance
		logic load_req;   // capture request
		logic mod_step;   // one restoring step of key % n
		logic rd;         // issue table read at probe index
		logic probe_next; // advance probe index
		logic commit;     // perform update and form result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic mod_done;
		logic bad_key;
		logic hit;        // key matches
		logic empty;      // slot empty
		logic pass_done;  // last probe of a full pass
	} dp_sts_t;

endpackage

@@ rtl/rhtpb_datapath.sv @@
// Datapath: configuration, key/count/page memories, modulo unit, probe and update.
// Depends on rhtpb_pkg.
`timescale 1ns / 1ps
module rhtpb_datapath #(
	parameter int SLOTS = 1024,
	parameter int KEY_WIDTH = 32,
	parameter int PAGE_ADDR_WIDTH = 20,
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [rhtpb_pkg::CFG_W-1:0] cfg_data,
	input  logic in_cmd,
	input  logic [31:0] in_key,
	input  logic [31:0] in_size,
	input  rhtpb_pkg::dp_cmd_t cmd,
	output rhtpb_pkg::dp_sts_t sts,
	output logic [2:0] status,
	output logic [9:0] slot,
	output logic [15:0] ref_count,
	output logic [19:0] first_page
);
	import rhtpb_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = AW + 1;
	localparam int MW = (32 > KEY_WIDTH) ? KEY_WIDTH : 32;
	localparam int KW = (MW > 1) ? $clog2(MW) : 1;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	logic [KEY_WIDTH-1:0]       keys_mem  [SLOTS];
	logic [COUNT_WIDTH-1:0]     cnt_mem   [SLOTS];
	logic [PAGE_ADDR_WIDTH-1:0] page_mem  [SLOTS];

	logic [10:0] slots_q;
	logic [4:0]  log2_q;
	logic [20:0] total_q;
	logic [PAGE_ADDR_WIDTH:0] nfp_q;
	logic [AW-1:0] clr_q;

	logic cmd_q;
	logic [MW-1:0] key_q;
	logic [31:0] size_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] rem_q;
	logic [KW-1:0] bit_q;
	logic [AW-1:0] idx_q;
	logic [NW-1:0] cnt_probe_q;
	logic [KEY_WIDTH-1:0] rkey_q;
	logic [COUNT_WIDTH-1:0] rcnt_q;
	logic [PAGE_ADDR_WIDTH-1:0] rpage_q;

	// clamp slot count into 1..SLOTS
	logic [NW-1:0] n_use;
	always_comb begin
		if (slots_q == 11'd0) n_use = NW'(1);
		else if ({21'd0, slots_q} > 32'(SLOTS)) n_use = NW'(SLOTS);
		else n_use = NW'(slots_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= 11'd1024;
			log2_q <= 5'd12;
			total_q <= 21'd1048576;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_TABLE_SLOTS: slots_q <= cfg_data[10:0];
				REG_PAGE_LOG2:   log2_q <= cfg_data[4:0];
				REG_TOTAL_PAGES: total_q <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	// page arithmetic for a possible insert
	logic [32:0] pages;
	logic [40:0] limit, nfp_ext, room;
	logic no_room, zero_size;
	always_comb begin
		pages = {1'b0, size_q >> log2_q} + 33'd1;
		limit = 41'(total_q);
		if (limit > (41'd1 << PAGE_ADDR_WIDTH)) limit = 41'd1 << PAGE_ADDR_WIDTH;
		nfp_ext = 41'(nfp_q);
		room = limit - nfp_ext;
		no_room = (nfp_ext > limit) || (41'(pages) > room);
		zero_size = (size_q == 32'd0);
	end

	// restoring modulo, one key bit a step
	logic [NW:0] rem_sh;
	always_comb rem_sh = {rem_q, key_q[bit_q]};

	// control registers of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfp_q <= '0;
			clr_q <= '0;
			bit_q <= '0;
		end else begin
			if (cfg_we && reg_idx_t'(cfg_idx) == REG_FIRST_PAGE)
				nfp_q <= (PAGE_ADDR_WIDTH + 1)'(cfg_data[19:0]);
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.load_req) bit_q <= KW'(MW - 1);
			else if (cmd.mod_step && bit_q != '0) bit_q <= bit_q - KW'(1);
			if (cmd.commit && !cmd_q && !sts.bad_key && !sts.hit && sts.empty &&
			    !zero_size && !no_room)
				nfp_q <= nfp_q + (PAGE_ADDR_WIDTH + 1)'(pages);
		end
	end

	// request capture, modulo and probe registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			cmd_q <= in_cmd;
			key_q <= MW'(in_key);
			size_q <= in_size;
			n_q <= n_use;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			if (rem_sh >= {1'b0, n_q}) rem_q <= NW'(rem_sh - {1'b0, n_q});
			else rem_q <= NW'(rem_sh);
			if (bit_q == '0) begin
				idx_q <= (rem_sh >= {1'b0, n_q}) ? AW'(rem_sh - {1'b0, n_q}) : AW'(rem_sh);
				cnt_probe_q <= NW'(1);
			end
		end else if (cmd.probe_next) begin
			idx_q <= (NW'(idx_q) + NW'(1) == n_q) ? '0 : idx_q + AW'(1);
			cnt_probe_q <= cnt_probe_q + NW'(1);
		end
	end

	// memories: one read, one write per cycle
	logic [COUNT_WIDTH-1:0] cnt_new;
	always_comb begin
		cnt_new = rcnt_q;
		if (!cmd_q) begin
			if (rcnt_q != CMAX) cnt_new = rcnt_q + COUNT_WIDTH'(1);
		end else if (rcnt_q != '0) cnt_new = rcnt_q - COUNT_WIDTH'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rkey_q <= keys_mem[idx_q];
			rcnt_q <= cnt_mem[idx_q];
			rpage_q <= page_mem[idx_q];
		end
		if (cmd.clr_step) begin
			keys_mem[clr_q] <= '0;
			cnt_mem[clr_q] <= '0;
		end else if (cmd.commit) begin
			if (sts.hit) begin
				if (cmd_q && cnt_new == '0) keys_mem[idx_q] <= '0;
				cnt_mem[idx_q] <= cnt_new;
			end else if (!cmd_q && !sts.bad_key && sts.empty && !zero_size && !no_room) begin
				keys_mem[idx_q] <= KEY_WIDTH'(key_q);
				cnt_mem[idx_q] <= COUNT_WIDTH'(1);
				page_mem[idx_q] <= nfp_q[PAGE_ADDR_WIDTH-1:0];
			end
		end
	end

	// result register
	logic [2:0] st_d;
	logic [9:0] sl_d;
	logic [15:0] rc_d;
	logic [19:0] pg_d;
	always_comb begin
		st_d = ST_NOTFOUND; sl_d = '0; rc_d = '0; pg_d = '0;
		if (sts.bad_key) st_d = ST_BADKEY;
		else if (!cmd_q) begin
			if (sts.hit) begin
				st_d = ST_HIT; sl_d = 10'(idx_q); rc_d = 16'(cnt_new); pg_d = 20'(rpage_q);
			end else if (!sts.empty) st_d = ST_FULL;
			else if (zero_size || no_room) st_d = ST_NOPAGES;
			else begin
				st_d = ST_INSERTED; sl_d = 10'(idx_q); rc_d = 16'd1; pg_d = 20'(nfp_q);
			end
		end else if (sts.hit) begin
			sl_d = 10'(idx_q);
			if (cnt_new == '0) st_d = ST_FREED;
			else begin st_d = ST_DECR; rc_d = 16'(cnt_new); end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status <= st_d; slot <= sl_d; ref_count <= rc_d; first_page <= pg_d;
		end
	end

	// status to controller
	always_comb begin
		sts.clr_done = (clr_q == AW'(SLOTS - 1));
		sts.mod_done = (bit_q == '0);
		sts.bad_key = (key_q == '0);
		sts.hit = (rkey_q == KEY_WIDTH'(key_q)) && !sts.bad_key;
		sts.empty = (rkey_q == '0);
		sts.pass_done = (cnt_probe_q == n_q);
	end
endmodule

@@ rtl/rhtpb_ctrl.sv @@
// Controller state machine: clear sweep, modulo, probe loop, commit and result hold.
// Depends on rhtpb_pkg.
`timescale 1ns / 1ps
module rhtpb_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  rhtpb_pkg::dp_sts_t sts,
	output rhtpb_pkg::dp_cmd_t cmd
);
	import rhtpb_pkg::*;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (sts.clr_done) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_MOD;
			S_MOD:   if (sts.mod_done) state_d = S_READ;
			S_READ:  state_d = S_CHECK;
			S_CHECK: begin
				if (sts.bad_key || sts.hit || sts.empty || sts.pass_done) state_d = S_OUT;
				else state_d = S_READ;
			end
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load_req = in_valid;
			end
			S_MOD: cmd.mod_step = 1'b1;
			S_READ: cmd.rd = 1'b1;
			S_CHECK: begin
				if (sts.bad_key || sts.hit || sts.empty || sts.pass_done) cmd.commit = 1'b1;
				else cmd.probe_next = 1'b1;
			end
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end
endmodule

@@ rtl/refcounted_hash_table_page_bump.sv @@
// Top level: refcounted open-addressing key table with page bump allocator.
// Instantiates rhtpb_ctrl and rhtpb_datapath; depends on rhtpb_pkg.
//
//  channel  handshake          payload
//  in       in_valid/in_stall  cmd, key, size_bytes
//  out      out_valid/out_stall status, slot, ref_count, first_page
//  cfg      cfg_we             cfg_idx, cfg_data
//
// A request is accepted, takes one modulo step per key bit, then a read and a
// check of each probed slot in turn; the last check commits and the result shows
// in the cycle after. Requests are handled one at a time; the remainder unit and
// the single table read port set how long each one takes.
// After reset a clearing pass empties the table; no request is taken meanwhile.
// The result is held until out_stall is low; the next request waits for it.
`timescale 1ns / 1ps
module refcounted_hash_table_page_bump #(
	parameter int SLOTS = 1024,
	parameter int KEY_WIDTH = 32,
	parameter int PAGE_ADDR_WIDTH = 20,
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [rhtpb_pkg::CFG_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  logic [31:0] key,
	input  logic [31:0] size_bytes,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] status,
	output logic [9:0] slot,
	output logic [15:0] ref_count,
	output logic [19:0] first_page
);
	import rhtpb_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;

	rhtpb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.sts(dsts), .cmd(dcmd)
	);

	rhtpb_datapath #(
		.SLOTS(SLOTS), .KEY_WIDTH(KEY_WIDTH),
		.PAGE_ADDR_WIDTH(PAGE_ADDR_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_cmd(cmd), .in_key(key), .in_size(size_bytes),
		.cmd(dcmd), .sts(dsts),
		.status(status), .slot(slot), .ref_count(ref_count), .first_page(first_page)
	);
endmodule
